@@ hdl/multiplexed_servo_pulse_generator_assert.svh @@
// Assertion macros used by the servo pulse generator checker.
`ifndef MULTIPLEXED_SERVO_PULSE_GENERATOR_ASSERT_SVH
`define MULTIPLEXED_SERVO_PULSE_GENERATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk and idle while arst_n is low.
`define MSP_ASSERT_HOLDS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and idle while arst_n is low.
`define MSP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/msp_pkg.sv @@
// Shared types and constants of the multiplexed servo pulse generator.
package msp_pkg;

	// Width of every configuration register data word and of the width input.
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 3;
	localparam int COUNT_W   = 4;
	localparam int SEL_W     = 3;
	localparam int PIN_COUNT = 8;
	localparam int PIN_IDX_W = 3;

	// Register values after reset.
	localparam logic [CFG_W-1:0]   MIN_PULSE_RST    = 12'd500;
	localparam logic [CFG_W-1:0]   MAX_PULSE_RST    = 12'd2500;
	localparam logic [CFG_W-1:0]   SLOT_LENGTH_RST  = 12'd2500;
	localparam logic [CFG_W-1:0]   MIN_LOW_TIME_RST = 12'd20;
	localparam logic [COUNT_W-1:0] SERVO_COUNT_RST  = 4'd8;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_PULSE    = 3'd0,
		CFG_MAX_PULSE    = 3'd1,
		CFG_SLOT_LENGTH  = 3'd2,
		CFG_MIN_LOW_TIME = 3'd3,
		CFG_SERVO_COUNT  = 3'd4
	} msp_cfg_reg_t;

	// Input item kinds.
	typedef enum logic {
		CMD_TICK  = 1'b0,
		CMD_WRITE = 1'b1
	} msp_cmd_t;

endpackage

@@ hdl/msp_phase_calc.sv @@
// Clamps the active servo's width and works out the length of the next phase.
module msp_phase_calc #(
	parameter int TICK_BITS = 12
) (
	input  logic [TICK_BITS-1:0]      width,
	input  logic [msp_pkg::CFG_W-1:0] min_pulse,
	input  logic [msp_pkg::CFG_W-1:0] max_pulse,
	input  logic [msp_pkg::CFG_W-1:0] slot_length,
	input  logic [msp_pkg::CFG_W-1:0] min_low_time,
	input  logic                      phase_low,
	output logic [TICK_BITS-1:0]      clamped,
	output logic [TICK_BITS-1:0]      length
);
	import msp_pkg::*;

	// Common compare width covering both the tick counter and the registers.
	localparam int CW = (TICK_BITS > CFG_W) ? TICK_BITS : CFG_W;

	logic [CW-1:0]        w_ext;
	logic [CW-1:0]        w_max;
	logic [CW-1:0]        w_min;
	logic [CW-1:0]        w_stored;
	logic [CW-1:0]        slot_ext;
	logic [CW-1:0]        low_ext;
	logic [CW-1:0]        slot_rest;
	logic [CW-1:0]        len_ext;
	logic [TICK_BITS-1:0] len_trunc;

	// Clamp: the upper bound first, then the lower bound, so the lower one wins.
	always_comb begin
		w_ext = CW'(width);
		w_max = (w_ext > CW'(max_pulse)) ? CW'(max_pulse) : w_ext;
		w_min = (w_max < CW'(min_pulse)) ? CW'(min_pulse) : w_max;
		clamped = TICK_BITS'(w_min);
		w_stored = CW'(clamped);
	end

	// The low phase fills the rest of the slot but never drops below the minimum.
	always_comb begin
		slot_ext  = CW'(slot_length);
		low_ext   = CW'(min_low_time);
		slot_rest = slot_ext - w_stored;
		if (!phase_low) begin
			len_ext = w_stored;
		end else if (slot_ext > w_stored && slot_rest >= low_ext) begin
			len_ext = slot_rest;
		end else begin
			len_ext = low_ext;
		end
		len_trunc = TICK_BITS'(len_ext);
		// A zero-length phase still takes one tick.
		length = (len_trunc == '0) ? TICK_BITS'(1) : len_trunc;
	end

endmodule

@@ hdl/multiplexed_servo_pulse_generator.sv @@
// Top level of the multiplexed servo pulse generator.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_ready    command, servo_select, pulse_width
//   out      out_valid / out_ready  servo_pins, active_servo, in_high_phase, slot_finished
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item is taken per clock unless stalled; its result is registered the cycle after.
// The slot state and the width table update in the same cycle that the item is taken.
// A new item is taken while the output register is empty or being emptied in that cycle.
// A stall on the output side holds the result and stops further input transfers.
// Reset clears the width table, the slot state and the output valid, and loads the
// register defaults; configuration writes are always taken.
module multiplexed_servo_pulse_generator #(
	parameter int MAX_SERVOS = 8,
	parameter int TICK_BITS  = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic [msp_pkg::SEL_W-1:0]     servo_select,
	input  logic [msp_pkg::CFG_W-1:0]     pulse_width,

	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [msp_pkg::PIN_COUNT-1:0] servo_pins,
	output logic [msp_pkg::PIN_IDX_W-1:0] active_servo,
	output logic                          in_high_phase,
	output logic                          slot_finished,

	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [msp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [msp_pkg::CFG_W-1:0]     cfg_data
);
	import msp_pkg::*;

	localparam int IDX_W = (MAX_SERVOS > 1) ? $clog2(MAX_SERVOS) : 1;

	// Configuration registers.
	logic [CFG_W-1:0]   min_pulse_q;
	logic [CFG_W-1:0]   max_pulse_q;
	logic [CFG_W-1:0]   slot_length_q;
	logic [CFG_W-1:0]   min_low_time_q;
	logic [COUNT_W-1:0] servo_count_q;

	// Slot state and width table.
	logic [TICK_BITS-1:0] width_table_q [MAX_SERVOS];
	logic [IDX_W-1:0]     current_q;
	logic                 phase_low_q;
	logic [TICK_BITS-1:0] ticks_left_q;

	// Output register.
	logic                 out_valid_q;
	logic [PIN_COUNT-1:0] servo_pins_q;
	logic [PIN_IDX_W-1:0] active_servo_q;
	logic                 high_q;
	logic                 finished_q;

	logic                 accept;
	logic                 is_write;
	logic                 sel_in_range;
	logic [IDX_W-1:0]     sel_idx;
	logic [TICK_BITS-1:0] clamped;
	logic [TICK_BITS-1:0] phase_len;
	logic                 phase_start;
	logic [TICK_BITS-1:0] ticks_run;
	logic [TICK_BITS-1:0] ticks_next;
	logic                 phase_end;
	logic [IDX_W:0]       next_raw;
	logic [IDX_W-1:0]     next_idx;
	logic                 high_now;
	logic                 finished_now;
	logic [PIN_COUNT-1:0] pins_now;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign is_write  = (command == CMD_WRITE);

	// Clamp and phase length for the active servo.
	msp_phase_calc #(
		.TICK_BITS (TICK_BITS)
	) u_calc (
		.width        (width_table_q[current_q]),
		.min_pulse    (min_pulse_q),
		.max_pulse    (max_pulse_q),
		.slot_length  (slot_length_q),
		.min_low_time (min_low_time_q),
		.phase_low    (phase_low_q),
		.clamped      (clamped),
		.length       (phase_len)
	);

	// Tick countdown, phase end and the index of the next servo.
	always_comb begin
		phase_start  = (ticks_left_q == '0);
		ticks_run    = phase_start ? phase_len : ticks_left_q;
		ticks_next   = ticks_run - TICK_BITS'(1);
		phase_end    = (ticks_next == '0);
		next_raw     = {1'b0, current_q} + (IDX_W + 1)'(1);
		if (32'(next_raw) >= 32'(servo_count_q) || 32'(next_raw) >= MAX_SERVOS) begin
			next_idx = '0;
		end else begin
			next_idx = IDX_W'(next_raw);
		end
		sel_in_range = (32'(servo_select) < MAX_SERVOS);
		sel_idx      = IDX_W'(servo_select);
	end

	// Result fields of the item being taken.
	always_comb begin
		if (is_write) begin
			high_now     = !phase_start && !phase_low_q;
			finished_now = 1'b0;
		end else begin
			high_now     = !phase_low_q;
			finished_now = phase_end && phase_low_q;
		end
		if (high_now && 32'(current_q) < PIN_COUNT) begin
			pins_now = PIN_COUNT'(1) << current_q;
		end else begin
			pins_now = '0;
		end
	end

	// Configuration register writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pulse_q    <= MIN_PULSE_RST;
			max_pulse_q    <= MAX_PULSE_RST;
			slot_length_q  <= SLOT_LENGTH_RST;
			min_low_time_q <= MIN_LOW_TIME_RST;
			servo_count_q  <= SERVO_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MIN_PULSE:    min_pulse_q    <= cfg_data;
				CFG_MAX_PULSE:    max_pulse_q    <= cfg_data;
				CFG_SLOT_LENGTH:  slot_length_q  <= cfg_data;
				CFG_MIN_LOW_TIME: min_low_time_q <= cfg_data;
				CFG_SERVO_COUNT:  servo_count_q  <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Width table: host writes, and the clamped width written back at a phase start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SERVOS; i++) begin
				width_table_q[i] <= '0;
			end
		end else if (accept) begin
			if (is_write) begin
				if (sel_in_range) begin
					width_table_q[sel_idx] <= TICK_BITS'(pulse_width);
				end
			end else if (phase_start) begin
				width_table_q[current_q] <= clamped;
			end
		end
	end

	// Slot sequencing on timer ticks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_q    <= '0;
			phase_low_q  <= 1'b0;
			ticks_left_q <= '0;
		end else if (accept && !is_write) begin
			ticks_left_q <= ticks_next;
			if (phase_end) begin
				phase_low_q <= !phase_low_q;
				if (phase_low_q) begin
					current_q <= next_idx;
				end
			end
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			servo_pins_q   <= pins_now;
			active_servo_q <= PIN_IDX_W'(current_q);
			high_q         <= high_now;
			finished_q     <= finished_now;
		end
	end

	assign out_valid     = out_valid_q;
	assign servo_pins    = servo_pins_q;
	assign active_servo  = active_servo_q;
	assign in_high_phase = high_q;
	assign slot_finished = finished_q;

endmodule

@@ hdl/msp_checker.sv @@
// Port-level checker for the servo pulse generator, bound to the top level.
`include "multiplexed_servo_pulse_generator_assert.svh"

module msp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [msp_pkg::PIN_COUNT-1:0] servo_pins,
	input logic                          in_high_phase,
	input logic                          slot_finished
);
	import msp_pkg::*;

	// A result that is not taken stays offered with the same pins.
	`MSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(servo_pins), "result dropped or changed under stall")

	// At most one servo pin is high at a time.
	`MSP_ASSERT_HOLDS(a_pins_onehot, out_valid, $onehot0(servo_pins), "more than one servo pin high")

	// Pins are low whenever no high phase is reported.
	`MSP_ASSERT_HOLDS(a_pins_low, out_valid && !in_high_phase, servo_pins == '0, "servo pin high outside a high phase")

	// A slot only ends at the close of a low phase.
	`MSP_ASSERT_HOLDS(a_finish_low, out_valid && slot_finished, !in_high_phase, "slot finished during a high phase")

endmodule

bind multiplexed_servo_pulse_generator msp_checker u_msp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.servo_pins    (servo_pins),
	.in_high_phase (in_high_phase),
	.slot_finished (slot_finished)
);
